### rtl/core/color_lut_diagonal_interp_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color LUT diagonal interpolation unit
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COLOR_LUT_DIAGONAL_INTERP_UNIT_ASSERT_SVH
`define COLOR_LUT_DIAGONAL_INTERP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CLUT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLUT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/clut_pkg.sv
// ----------------------------------------------------------------------------
// clut_pkg
// Shared constants and types of the color LUT diagonal interpolation unit.
// ----------------------------------------------------------------------------
package clut_pkg;

    localparam int GRID_POINTS         = 32;
    localparam int COMPONENT_FRAC_BITS = 16;
    localparam int CELL_WIDTH          = 256 / GRID_POINTS;
    localparam int TABLE_SIZE          = GRID_POINTS * GRID_POINTS * GRID_POINTS;

    localparam int CH_N    = 3;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 15;
    localparam int COMP_W  = COMPONENT_FRAC_BITS + 1;
    localparam int ENTRY_W = CH_N * COMP_W;
    localparam int FRAC_W  = $clog2(CELL_WIDTH);
    localparam int GIDX_W  = $clog2(GRID_POINTS);

    // Blend arithmetic: num = s*(CELL-f) + e*f, out = num*255 >> DEN_SHIFT.
    localparam int WGT_W     = FRAC_W + 1;
    localparam int NUM_W     = COMP_W + FRAC_W;
    localparam int PROD_W    = NUM_W + 8;
    localparam int DEN_SHIFT = FRAC_W + COMPONENT_FRAC_BITS;
    localparam int Q_W       = PROD_W - DEN_SHIFT;
    localparam int OUT_MAX   = 255;

    localparam int IN_TDATA_BITS  = IDX_W + ENTRY_W + CH_N * PIX_W;
    localparam int IN_TDATA_W     = ((IN_TDATA_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = CH_N * PIX_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Channel 0 is red, 1 green, 2 blue; red sits in the lowest bits.
    typedef logic [CH_N-1:0][COMP_W-1:0] t_entry;
    typedef logic [CH_N-1:0][FRAC_W-1:0] t_frac;

    // Command passed from the front end to the back end. A write uses
    // addr_a and entry; a pixel uses addr_a (base), addr_b (diagonal) and frac.
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
        t_entry           entry;
        t_frac            frac;
    } t_cmd;

endpackage

### rtl/core/clut_ram.sv
// ----------------------------------------------------------------------------
// clut_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module clut_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/clut_front.sv
// ----------------------------------------------------------------------------
// clut_front
// Accepts input items, keeps the table-loaded flag and turns each kept item
// into a memory command: a table write or a pair of grid reads with fractions.
// ----------------------------------------------------------------------------
module clut_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [clut_pkg::IDX_W-1:0]           i_index,
    input  clut_pkg::t_entry                     i_entry,
    input  logic [clut_pkg::CH_N-1:0][clut_pkg::PIX_W-1:0] i_pix,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output clut_pkg::t_cmd                       o_cmd,
    output logic                                 o_loaded
);

    localparam int HI_W      = clut_pkg::PIX_W - clut_pkg::FRAC_W;
    localparam int DIAG_STEP = 1 + clut_pkg::GRID_POINTS
                             + clut_pkg::GRID_POINTS * clut_pkg::GRID_POINTS;

    logic                                              r_loaded;
    logic                                              n_loaded;
    logic                                              w_accept;
    logic                                              w_idx_ok;
    logic [clut_pkg::CH_N-1:0][clut_pkg::GIDX_W-1:0]   w_gidx;
    logic [clut_pkg::IDX_W-1:0]                        w_base;
    logic [clut_pkg::IDX_W:0]                          w_diag;
    clut_pkg::t_frac                                   w_frac;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_idx_ok = 32'(i_index) < clut_pkg::TABLE_SIZE;

    always_comb begin
        for (int k = 0; k < clut_pkg::CH_N; k++) begin
            // Grid index is the pixel value over the cell width, clamped so
            // that the diagonal neighbor stays inside the grid.
            if (i_pix[k][clut_pkg::PIX_W-1:clut_pkg::FRAC_W] >
                HI_W'(clut_pkg::GRID_POINTS - 2)) begin
                w_gidx[k] = clut_pkg::GIDX_W'(clut_pkg::GRID_POINTS - 2);
            end else begin
                w_gidx[k] = clut_pkg::GIDX_W'(
                    i_pix[k][clut_pkg::PIX_W-1:clut_pkg::FRAC_W]);
            end
            w_frac[k] = i_pix[k][clut_pkg::FRAC_W-1:0];
        end
        w_base = clut_pkg::IDX_W'(w_gidx[0])
               + clut_pkg::IDX_W'(w_gidx[1]) * clut_pkg::IDX_W'(clut_pkg::GRID_POINTS)
               + clut_pkg::IDX_W'(w_gidx[2])
                 * clut_pkg::IDX_W'(clut_pkg::GRID_POINTS * clut_pkg::GRID_POINTS);
        w_diag = (clut_pkg::IDX_W+1)'(w_base) + (clut_pkg::IDX_W+1)'(DIAG_STEP);
        if (32'(w_diag) >= clut_pkg::TABLE_SIZE) begin
            w_diag = (clut_pkg::IDX_W+1)'(clut_pkg::TABLE_SIZE - 1);
        end
    end

    always_comb begin
        o_cmd.op     = i_op;
        o_cmd.entry  = i_entry;
        o_cmd.frac   = w_frac;
        o_cmd.addr_b = w_diag[clut_pkg::IDX_W-1:0];
        if (i_op == clut_pkg::OP_WRITE) begin
            o_cmd.addr_a = i_index;
            o_push       = w_accept && w_idx_ok;
        end else begin
            o_cmd.addr_a = w_base;
            // Pixels that arrive before the table is loaded are dropped.
            o_push       = w_accept && r_loaded;
        end
    end

    always_comb begin
        n_loaded = r_loaded;
        if (w_accept && i_op == clut_pkg::OP_WRITE &&
            32'(i_index) == clut_pkg::TABLE_SIZE - 1) begin
            n_loaded = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
        end else begin
            r_loaded <= n_loaded;
        end
    end

    assign o_loaded = r_loaded;

endmodule

### rtl/core/clut_queue.sv
// ----------------------------------------------------------------------------
// clut_queue
// Small first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module clut_queue #(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  clut_pkg::t_cmd               i_push_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output clut_pkg::t_cmd               o_pop_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clut_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_empty   = r_count == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd_ptr];
    assign o_count    = r_count;

endmodule

### rtl/core/clut_back.sv
// ----------------------------------------------------------------------------
// clut_back
// Executes queued commands against the table memory and blends the two
// fetched entries per channel into the saturated 8-bit result.
// ----------------------------------------------------------------------------
module clut_back (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_q_empty,
    input  clut_pkg::t_cmd                                  i_cmd,
    output logic                                            o_pop,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [clut_pkg::CH_N-1:0][clut_pkg::PIX_W-1:0]  o_pix
);

    logic                                              w_en;
    logic                                              w_we;
    clut_pkg::t_entry                                  w_rd_base;
    clut_pkg::t_entry                                  w_rd_diag;

    logic                                              r_p1_valid;
    clut_pkg::t_frac                                   r_p1_frac;
    logic                                              r_p2_valid;
    logic [clut_pkg::CH_N-1:0][clut_pkg::NUM_W-1:0]    r_p2_num;
    logic [clut_pkg::CH_N-1:0][clut_pkg::NUM_W-1:0]    n_p2_num;
    logic                                              r_out_valid;
    logic [clut_pkg::CH_N-1:0][clut_pkg::PIX_W-1:0]    r_out_pix;
    logic [clut_pkg::CH_N-1:0][clut_pkg::PIX_W-1:0]    n_out_pix;

    logic [clut_pkg::PROD_W-1:0]                       w_prod;
    logic [clut_pkg::Q_W-1:0]                          w_q;
    logic [clut_pkg::WGT_W-1:0]                        w_wgt;

    // The whole back pipeline advances together whenever the output
    // register is free or being emptied.
    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && !i_q_empty;
    assign w_we  = o_pop && (i_cmd.op == clut_pkg::OP_WRITE);

    clut_ram #(
        .WIDTH (clut_pkg::ENTRY_W),
        .DEPTH (clut_pkg::TABLE_SIZE)
    ) u_lut_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (i_cmd.addr_a),
        .i_wdata   (i_cmd.entry),
        .i_re      (w_en),
        .i_raddr_a (i_cmd.addr_a),
        .i_raddr_b (i_cmd.addr_b),
        .o_rdata_a (w_rd_base),
        .o_rdata_b (w_rd_diag)
    );

    // Weighted sum s*(CELL-f) + e*f, which equals s*CELL + f*(e-s) and
    // never goes negative for unsigned components.
    always_comb begin
        w_wgt = '0;
        for (int k = 0; k < clut_pkg::CH_N; k++) begin
            w_wgt = clut_pkg::WGT_W'(clut_pkg::CELL_WIDTH)
                  - clut_pkg::WGT_W'(r_p1_frac[k]);
            n_p2_num[k] = clut_pkg::NUM_W'(w_rd_base[k]) * clut_pkg::NUM_W'(w_wgt)
                        + clut_pkg::NUM_W'(w_rd_diag[k])
                          * clut_pkg::NUM_W'(r_p1_frac[k]);
        end
    end

    // Scale by 255 as a shift and subtract, then drop the cell and
    // fraction bits; the denominator is a power of two.
    always_comb begin
        w_prod = '0;
        w_q    = '0;
        for (int k = 0; k < clut_pkg::CH_N; k++) begin
            w_prod = {r_p2_num[k], 8'h00} - clut_pkg::PROD_W'(r_p2_num[k]);
            w_q    = w_prod[clut_pkg::PROD_W-1:clut_pkg::DEN_SHIFT];
            if (w_q > clut_pkg::Q_W'(clut_pkg::OUT_MAX)) begin
                n_out_pix[k] = clut_pkg::PIX_W'(clut_pkg::OUT_MAX);
            end else begin
                n_out_pix[k] = w_q[clut_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid  <= o_pop && (i_cmd.op == clut_pkg::OP_PIXEL);
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_frac <= i_cmd.frac;
            r_p2_num  <= n_p2_num;
            r_out_pix <= n_out_pix;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out_pix;

endmodule

### rtl/core/color_lut_diagonal_interp_unit.sv
// ----------------------------------------------------------------------------
// color_lut_diagonal_interp_unit
// 32x32x32 color lookup table with per-channel diagonal interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries both table writes and pixels; s_axis_tuser selects
//   which (0 writes a table entry, 1 grades a pixel). A write transfer stores
//   three Q1.16 components at entry_index and gives no result. Once the last
//   index has been written the table counts as loaded; pixel transfers that
//   arrive earlier are dropped without a result.
//   Each graded pixel yields one master transfer with the three 8-bit channels.
//   The accepting edge puts the item into the command queue; it then passes
//   the registered table read, the weighted sum and scaling with saturation
//   before m_axis_tvalid rises. Throughput is one item per cycle unless the
//   receiver stalls; the table memory has two read ports, so the base and
//   diagonal entries are fetched in the same cycle.
//   Reset clears the loaded flag, the queue and all valid bits; the table
//   contents are kept and must be rewritten before use.
//   When the receiver stalls, the back pipeline holds, the four-entry command
//   queue fills and s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
`include "color_lut_diagonal_interp_unit_assert.svh"

module color_lut_diagonal_interp_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // entry_index, entry_red, entry_green, entry_blue, pix_red, pix_green,
    // pix_blue from the lowest bit up, zero padding on top
    input  logic [clut_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // op
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_red, out_green, out_blue from the lowest bit up
    output logic [clut_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_LO  = 0;
    localparam int COMP_LO = IDX_LO + clut_pkg::IDX_W;
    localparam int PIX_LO  = COMP_LO + clut_pkg::ENTRY_W;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    logic [clut_pkg::IDX_W-1:0]                        w_index;
    clut_pkg::t_entry                                  w_entry;
    logic [clut_pkg::CH_N-1:0][clut_pkg::PIX_W-1:0]    w_pix_in;
    logic [clut_pkg::CH_N-1:0][clut_pkg::PIX_W-1:0]    w_pix_out;

    logic                                              w_q_full;
    logic                                              w_q_empty;
    logic                                              w_push;
    logic                                              w_pop;
    clut_pkg::t_cmd                                    w_push_cmd;
    clut_pkg::t_cmd                                    w_pop_cmd;
    logic [CNT_W-1:0]                                  w_q_count;
    logic                                              w_loaded;

    assign w_index  = s_axis_tdata[COMP_LO-1:IDX_LO];
    assign w_entry  = s_axis_tdata[PIX_LO-1:COMP_LO];
    assign w_pix_in = s_axis_tdata[PIX_LO+clut_pkg::CH_N*clut_pkg::PIX_W-1:PIX_LO];

    clut_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser),
        .i_index  (w_index),
        .i_entry  (w_entry),
        .i_pix    (w_pix_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd),
        .o_loaded (w_loaded)
    );

    clut_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_cmd),
        .o_empty     (w_q_empty),
        .o_count     (w_q_count)
    );

    clut_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_pop_cmd),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pix     (w_pix_out)
    );

    assign m_axis_tdata = w_pix_out;

    // No graded pixel can reach the output before the table is loaded.
    `CLUT_ASSERT_NOW(a_no_result_unloaded, !w_loaded, !m_axis_tvalid,
        "result transfer while table not loaded")

    // The loaded flag only ever sets.
    `CLUT_ASSERT_NEXT(a_loaded_sticky, w_loaded, w_loaded,
        "table loaded flag cleared")

    // The queue never holds more than its depth, and never pushes when full.
    `CLUT_ASSERT_NOW(a_queue_bound, w_push, w_q_count < CNT_W'(QUEUE_DEPTH),
        "command pushed into a full queue")

endmodule
